### sv/cfd_pkg.sv
package cfd_pkg;

    localparam int unsigned IN_TDATA_W  = 8;
    localparam int unsigned RESULT_W    = 59;
    localparam int unsigned OUT_TDATA_W = 64;
    localparam int unsigned POS_W       = 17;
    localparam int unsigned LEN_W       = 16;

    localparam logic [7:0]       START_BYTE     = 8'hA5;
    localparam logic [7:0]       END_BYTE       = 8'h96;
    localparam logic [17:0]      MIN_TOTAL      = 18'd9;
    localparam logic [LEN_W-1:0] MIN_PAYLOAD    = 16'd4;
    localparam logic [17:0]      FRAME_OVERHEAD = 18'd5;
    localparam logic [16:0]      HEADER_BYTES   = 17'd3;
    localparam logic [LEN_W-1:0] MAX_DATA       = 16'd256;

    localparam logic [POS_W-1:0] POS_START   = 17'd0;
    localparam logic [POS_W-1:0] POS_LEN_LO  = 17'd1;
    localparam logic [POS_W-1:0] POS_LEN_HI  = 17'd2;
    localparam logic [POS_W-1:0] POS_CTRL    = 17'd3;
    localparam logic [POS_W-1:0] POS_PSEQ    = 17'd4;
    localparam logic [POS_W-1:0] POS_FSEQ    = 17'd5;
    localparam logic [POS_W-1:0] POS_PROT    = 17'd6;
    localparam logic [POS_W-1:0] POS_DATA    = 17'd7;
    localparam logic [POS_W-1:0] POS_MAX     = 17'h1FFFF;

    localparam logic KIND_DATA  = 1'b0;
    localparam logic KIND_CLOSE = 1'b1;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_FRAMING   = 3'd2,
        ST_SMALL     = 3'd3,
        ST_LENGTH    = 3'd4,
        ST_SUM       = 3'd5,
        ST_TOO_LONG  = 3'd6
    } t_status;

    // first member sits in the highest bits
    typedef struct packed {
        logic [15:0] data_count;
        logic [7:0]  protocol_id;
        logic [7:0]  frame_seq;
        logic [7:0]  packet_seq;
        logic [3:0]  function_code;
        logic        fcv_bit;
        logic        fcb_bit;
        logic        prm_bit;
        logic        dir_bit;
        t_status     status;
        logic [7:0]  data_byte;
    } t_result;

endpackage

### sv/checksummed_frame_deframer_unit.sv
// an accepted byte is held in the input register, and its word is then registered in the result register
// throughput: one byte per cycle while the output is not stalled, set by the single compare and add stage
// the result register takes a new word while the previous one is being drained
// reset (synchronous, active low) clears the frame state and both valid flags
// after the final byte of a buffer the frame state returns to its reset value
module checksummed_frame_deframer_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // in_byte
    input  logic [cfd_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input  logic                             s_axis_tlast,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // data_byte, status, dir_bit, prm_bit, fcb_bit, fcv_bit, function_code,
    // packet_seq, frame_seq, protocol_id, data_count, zero pad
    output logic [cfd_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // kind
    output logic                             m_axis_tuser
);
    import cfd_pkg::*;

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_last;

    logic [POS_W-1:0] r_pos;
    logic             r_start_ok;
    logic [LEN_W-1:0] r_len;
    logic [7:0]       r_sum;
    logic [7:0]       r_ctrl;
    logic [7:0]       r_hdr [3];
    logic [7:0]       r_prev;

    logic             r_out_valid;
    logic             r_out_kind;
    t_result          r_out_data;

    logic             advance;
    logic             in_payload;
    logic [16:0]      payload_end;
    logic [17:0]      total;
    logic [17:0]      len_plus;
    logic             n_start_ok;
    logic [LEN_W-1:0] n_len;
    logic [7:0]       n_sum;
    logic [7:0]       n_ctrl;
    logic [7:0]       n_hdr [3];
    logic [LEN_W-1:0] n_count;
    t_status          n_status;
    t_result          n_result;
    logic             n_has_result;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_comb begin
        payload_end = {1'b0, r_len} + HEADER_BYTES;
        in_payload  = (r_pos >= POS_CTRL) && (r_pos < payload_end);

        n_start_ok = (r_pos == POS_START) ? (r_in_byte == START_BYTE) : r_start_ok;
        n_len      = r_len;
        if (r_pos == POS_LEN_LO) begin
            n_len[7:0] = r_in_byte;
        end else if (r_pos == POS_LEN_HI) begin
            n_len[15:8] = r_in_byte;
        end
        n_sum  = in_payload ? (r_sum + r_in_byte) : r_sum;
        n_ctrl = (r_pos == POS_CTRL) ? r_in_byte : r_ctrl;
        n_hdr[0] = (r_pos == POS_PSEQ) ? r_in_byte : r_hdr[0];
        n_hdr[1] = (r_pos == POS_FSEQ) ? r_in_byte : r_hdr[1];
        n_hdr[2] = (r_pos == POS_PROT) ? r_in_byte : r_hdr[2];

        total    = {1'b0, r_pos} + 18'd1;
        len_plus = {2'b00, n_len} + FRAME_OVERHEAD;
        n_count  = n_len - MIN_PAYLOAD;

        if (total < MIN_TOTAL) begin
            n_status = ST_SHORT;
        end else if (!n_start_ok || (r_in_byte != END_BYTE)) begin
            n_status = ST_FRAMING;
        end else if (n_len < MIN_PAYLOAD) begin
            n_status = ST_SMALL;
        end else if (total != len_plus) begin
            n_status = ST_LENGTH;
        end else if (n_sum != r_prev) begin
            n_status = ST_SUM;
        end else if (n_count > MAX_DATA) begin
            n_status = ST_TOO_LONG;
        end else begin
            n_status = ST_OK;
        end

        n_result = '0;
        if (r_in_last) begin
            n_result.status = n_status;
            if (n_status == ST_OK) begin
                n_result.dir_bit       = n_ctrl[7];
                n_result.prm_bit       = n_ctrl[6];
                n_result.fcb_bit       = n_ctrl[5];
                n_result.fcv_bit       = n_ctrl[4];
                n_result.function_code = n_ctrl[3:0];
                n_result.packet_seq    = n_hdr[0];
                n_result.frame_seq     = n_hdr[1];
                n_result.protocol_id   = n_hdr[2];
                n_result.data_count    = n_count;
            end
        end else begin
            n_result.data_byte = r_in_byte;
        end

        n_has_result = r_in_last || ((r_pos >= POS_DATA) && (r_pos < payload_end));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (advance && r_in_last)) begin
            r_pos      <= '0;
            r_start_ok <= 1'b0;
            r_len      <= '0;
            r_sum      <= '0;
            r_ctrl     <= '0;
            r_hdr[0]   <= '0;
            r_hdr[1]   <= '0;
            r_hdr[2]   <= '0;
            r_prev     <= '0;
        end else if (advance) begin
            if (r_pos != POS_MAX) begin
                r_pos <= r_pos + 17'd1;
            end
            r_start_ok <= n_start_ok;
            r_len      <= n_len;
            r_sum      <= n_sum;
            r_ctrl     <= n_ctrl;
            r_hdr[0]   <= n_hdr[0];
            r_hdr[1]   <= n_hdr[1];
            r_hdr[2]   <= n_hdr[2];
            r_prev     <= r_in_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= n_has_result;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && n_has_result) begin
            r_out_data <= n_result;
            r_out_kind <= r_in_last ? KIND_CLOSE : KIND_DATA;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tdata  = {{(OUT_TDATA_W - RESULT_W){1'b0}}, r_out_data};

endmodule
